// ===== hdl/gsp_pkg.sv =====
// Package: shared types and constants for the Gauss-Seidel Poisson solver.
package gsp_pkg;

    localparam int GRID_STRIDE = 64;
    localparam int ADDR_BITS   = 12;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] REG_GRID_N      = 2'd0;
    localparam logic [1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [1:0] REG_SOURCE_TERM = 2'd2;
    localparam logic [1:0] REG_MAX_SWEEPS  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_SWEEP_START,
        ST_FETCH_UP,
        ST_FETCH_DOWN,
        ST_FETCH_LEFT,
        ST_FETCH_RIGHT,
        ST_FETCH_OLD,
        ST_UPDATE,
        ST_SWEEP_END,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        SEL_UP,
        SEL_DOWN,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_CENTRE,
        SEL_HOST
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t  addr_sel;
        logic       mem_we_host;
        logic       mem_we_cell;
        logic [2:0] load_slot;
        logic       load_en;
        logic       read_capture;
        logic       read_clear;
        logic       sweep_init;
        logic       cell_first;
        logic       cell_next;
        logic       sweep_finish;
        logic       run_init;
    } dp_cmd_t;

    typedef struct packed {
        logic last_cell;
        logic empty_grid;
        logic stop_run;
    } dp_status_t;

endpackage

// ===== hdl/gauss_seidel_poisson_grid_solver.sv =====
// Top level: Gauss-Seidel Poisson solver with command port and register port.
// Every item ends with a done strobe. A run item sweeps the n*n interior cells
// (n = grid_n, at most 62) until it converges or reaches the sweep limit: each interior cell needs
// five reads of the single-port grid memory plus the write back, in raster order.
// The result appears for one cycle with done high; the receiver cannot stall it.
module gauss_seidel_poisson_grid_solver
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] cell_value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [15:0]        sweep_count,
    output logic               converged,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    gsp_pkg::dp_cmd_t    cmd;
    gsp_pkg::dp_status_t status;

    logic [5:0]         grid_n_reg;
    logic [30:0]        tolerance_reg;
    logic signed [31:0] source_term_reg;
    logic [15:0]        max_sweeps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_n_reg      <= 6'd62;
            tolerance_reg   <= 31'd16777;
            source_term_reg <= 32'sd4227;
            max_sweeps_reg  <= 16'd65535;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gsp_pkg::REG_GRID_N:      grid_n_reg      <= cfg_data[5:0];
                gsp_pkg::REG_TOLERANCE:   tolerance_reg   <= cfg_data[30:0];
                gsp_pkg::REG_SOURCE_TERM: source_term_reg <= cfg_data;
                gsp_pkg::REG_MAX_SWEEPS:  max_sweeps_reg  <= cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    gsp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gsp_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .row         (row),
        .col         (col),
        .cell_value  (cell_value),
        .grid_n      (grid_n_reg),
        .tolerance   (tolerance_reg),
        .source_term (source_term_reg),
        .max_sweeps  (max_sweeps_reg),
        .cmd         (cmd),
        .status      (status),
        .read_value  (read_value),
        .sweep_count (sweep_count),
        .converged   (converged)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobe outside a busy item");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_we_host && cmd.mem_we_cell))
        else $error("two memory writes in one cycle");

endmodule

// ===== hdl/gsp_ctrl.sv =====
// Controller: sequences memory accesses for write, read and run items.
module gsp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          kind,
    input  gsp_pkg::dp_status_t status,
    output gsp_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    gsp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = gsp_pkg::SEL_HOST;
        busy         = 1'b1;
        done         = 1'b0;
        unique case (state_reg)
            gsp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (kind)
                        gsp_pkg::KIND_WRITE: state_next = gsp_pkg::ST_WRITE;
                        gsp_pkg::KIND_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = gsp_pkg::ST_SWEEP_START;
                        end
                        gsp_pkg::KIND_READ: state_next = gsp_pkg::ST_READ;
                        default:
                        begin
                            cmd.read_clear = 1'b1;
                            state_next     = gsp_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            gsp_pkg::ST_WRITE:
            begin
                cmd.mem_we_host = 1'b1;
                cmd.read_clear  = 1'b1;
                state_next      = gsp_pkg::ST_RESULT;
            end
            gsp_pkg::ST_READ:
            begin
                state_next = gsp_pkg::ST_READ_WAIT;
            end
            gsp_pkg::ST_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = gsp_pkg::ST_RESULT;
            end
            gsp_pkg::ST_SWEEP_START:
            begin
                cmd.sweep_init = 1'b1;
                state_next = status.empty_grid ? gsp_pkg::ST_SWEEP_END
                                               : gsp_pkg::ST_FETCH_UP;
            end
            gsp_pkg::ST_FETCH_UP:
            begin
                cmd.addr_sel = gsp_pkg::SEL_UP;
                state_next   = gsp_pkg::ST_FETCH_DOWN;
            end
            gsp_pkg::ST_FETCH_DOWN:
            begin
                cmd.addr_sel  = gsp_pkg::SEL_DOWN;
                cmd.load_en   = 1'b1;
                cmd.load_slot = 3'd0;
                state_next    = gsp_pkg::ST_FETCH_LEFT;
            end
            gsp_pkg::ST_FETCH_LEFT:
            begin
                cmd.addr_sel  = gsp_pkg::SEL_LEFT;
                cmd.load_en   = 1'b1;
                cmd.load_slot = 3'd1;
                state_next    = gsp_pkg::ST_FETCH_RIGHT;
            end
            gsp_pkg::ST_FETCH_RIGHT:
            begin
                cmd.addr_sel  = gsp_pkg::SEL_RIGHT;
                cmd.load_en   = 1'b1;
                cmd.load_slot = 3'd2;
                state_next    = gsp_pkg::ST_FETCH_OLD;
            end
            gsp_pkg::ST_FETCH_OLD:
            begin
                cmd.addr_sel  = gsp_pkg::SEL_CENTRE;
                cmd.load_en   = 1'b1;
                cmd.load_slot = 3'd3;
                state_next    = gsp_pkg::ST_UPDATE;
            end
            gsp_pkg::ST_UPDATE:
            begin
                // old word is on the read register now; write the new cell and move on
                cmd.addr_sel    = gsp_pkg::SEL_CENTRE;
                cmd.mem_we_cell = 1'b1;
                cmd.cell_next   = 1'b1;
                state_next = status.last_cell ? gsp_pkg::ST_SWEEP_END
                                              : gsp_pkg::ST_FETCH_UP;
            end
            gsp_pkg::ST_SWEEP_END:
            begin
                cmd.sweep_finish = 1'b1;
                state_next = status.stop_run ? gsp_pkg::ST_RESULT
                                             : gsp_pkg::ST_SWEEP_START;
                cmd.read_clear = status.stop_run;
            end
            gsp_pkg::ST_RESULT:
            begin
                done       = 1'b1;
                state_next = gsp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gsp_datapath.sv =====
// Datapath: grid memory, stencil arithmetic, sweep counters and result registers.
module gsp_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic signed [31:0]  cell_value,
    input  logic [5:0]          grid_n,
    input  logic [30:0]         tolerance,
    input  logic signed [31:0]  source_term,
    input  logic [15:0]         max_sweeps,
    input  gsp_pkg::dp_cmd_t    cmd,
    output gsp_pkg::dp_status_t status,
    output logic signed [31:0]  read_value,
    output logic [15:0]         sweep_count,
    output logic                converged
);

    logic signed [31:0] grid_mem [gsp_pkg::GRID_STRIDE * gsp_pkg::GRID_STRIDE];
    logic signed [31:0] rd_data_reg;

    logic [5:0]  host_row_reg, host_col_reg;
    logic signed [31:0] host_val_reg;
    logic [5:0]  i_reg, j_reg;
    logic [5:0]  n_reg;
    logic [15:0] limit_reg;
    logic [15:0] count_reg;
    logic [31:0] big_reg;
    logic signed [31:0] up_reg, down_reg, left_reg, right_reg;
    logic [15:0] sweeps_reg;
    logic        conv_reg;
    logic signed [31:0] read_reg;

    logic [gsp_pkg::ADDR_BITS-1:0] addr;
    logic [gsp_pkg::ADDR_BITS-1:0] centre;
    logic signed [34:0] sum;
    logic signed [32:0] quarter;
    logic signed [31:0] stencil_val;
    logic signed [32:0] delta2;
    logic [31:0] abs_delta2;

    assign centre = {i_reg, j_reg};

    always_comb
    begin
        case (cmd.addr_sel)
            gsp_pkg::SEL_UP:     addr = centre - gsp_pkg::ADDR_BITS'(gsp_pkg::GRID_STRIDE);
            gsp_pkg::SEL_DOWN:   addr = centre + gsp_pkg::ADDR_BITS'(gsp_pkg::GRID_STRIDE);
            gsp_pkg::SEL_LEFT:   addr = centre - gsp_pkg::ADDR_BITS'(1);
            gsp_pkg::SEL_RIGHT:  addr = centre + gsp_pkg::ADDR_BITS'(1);
            gsp_pkg::SEL_CENTRE: addr = centre;
            default:             addr = {host_row_reg, host_col_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we_host)
        begin
            grid_mem[{host_row_reg, host_col_reg}] <= host_val_reg;
        end
        else if (cmd.mem_we_cell)
        begin
            grid_mem[centre] <= stencil_val;
        end
        rd_data_reg <= grid_mem[addr];
    end

    // floor of sum/4 is an arithmetic shift; result always fits 33 bits
    assign sum = 35'(up_reg) + 35'(down_reg) + 35'(left_reg) + 35'(right_reg)
               - 35'(source_term);
    assign quarter = 33'(sum >>> 2);
    assign stencil_val = (quarter > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                         (quarter < -33'sh080000000) ? 32'sh80000000 : quarter[31:0];

    // in UPDATE the old word arrives on rd_data_reg; stencil inputs are all loaded
    assign delta2     = 33'(stencil_val) - 33'(rd_data_reg);
    assign abs_delta2 = delta2[32] ? 32'(-delta2) : delta2[31:0];

    assign status.last_cell  = (j_reg == n_reg) && (i_reg == n_reg);
    assign status.empty_grid = (n_reg == 6'd0);
    assign status.stop_run   = (big_reg <= {1'b0, tolerance}) || (count_reg >= limit_reg);

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            host_row_reg <= row;
            host_col_reg <= col;
            host_val_reg <= cell_value;
        end
        if (cmd.load_en)
        begin
            case (cmd.load_slot)
                3'd0:    up_reg    <= rd_data_reg;
                3'd1:    down_reg  <= rd_data_reg;
                3'd2:    left_reg  <= rd_data_reg;
                default: right_reg <= rd_data_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= 6'd1;
            j_reg      <= 6'd1;
            n_reg      <= 6'd0;
            limit_reg  <= 16'd1;
            count_reg  <= 16'd0;
            big_reg    <= 32'd0;
            sweeps_reg <= 16'd0;
            conv_reg   <= 1'b0;
            read_reg   <= 32'sd0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                n_reg     <= (grid_n > 6'd62) ? 6'd62 : grid_n;
                limit_reg <= (max_sweeps == 16'd0) ? 16'd1 : max_sweeps;
                count_reg <= 16'd0;
            end
            if (cmd.sweep_init)
            begin
                i_reg     <= 6'd1;
                j_reg     <= 6'd1;
                big_reg   <= 32'd0;
                count_reg <= count_reg + 16'd1;
            end
            if (cmd.cell_next)
            begin
                if (abs_delta2 > big_reg)
                begin
                    big_reg <= abs_delta2;
                end
                if (j_reg == n_reg)
                begin
                    j_reg <= 6'd1;
                    i_reg <= i_reg + 6'd1;
                end
                else
                begin
                    j_reg <= j_reg + 6'd1;
                end
            end
            if (cmd.sweep_finish && status.stop_run)
            begin
                sweeps_reg <= count_reg;
                conv_reg   <= (big_reg <= {1'b0, tolerance});
            end
            if (cmd.read_capture)
            begin
                read_reg <= ((host_row_reg <= 6'd63) && (host_col_reg <= 6'd63))
                            ? rd_data_reg : 32'sd0;
            end
            else if (cmd.read_clear)
            begin
                read_reg <= 32'sd0;
            end
        end
    end

    assign read_value  = read_reg;
    assign sweep_count = sweeps_reg;
    assign converged   = conv_reg;

endmodule

// ===== tb/gauss_seidel_poisson_grid_solver_tb.sv =====
// Testbench for the Gauss-Seidel Poisson solver: queued command words, in-line prediction.
module gauss_seidel_poisson_grid_solver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1950;

    typedef struct {
        logic [1:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } cmd_word_t;

    typedef struct {
        logic signed [31:0] read_value;
        logic [15:0]        sweep_count;
        logic               converged;
    } status_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] cell_value;
    logic               done;
    logic signed [31:0] read_value;
    logic [15:0]        sweep_count;
    logic               converged;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    gauss_seidel_poisson_grid_solver uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .row(row), .col(col), .cell_value(cell_value),
        .done(done), .read_value(read_value), .sweep_count(sweep_count),
        .converged(converged), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cmd_word_t    pending_cmds[$];
    status_word_t awaited_status[$];
    int           errors = 0;
    int           cycles = 0;

    // solver image kept by the testbench
    logic signed [31:0] grid_image [0:4095];
    logic [15:0]        last_sweeps = '0;
    logic               last_converged = 1'b0;
    logic [5:0]         size_reg = 6'd62;
    logic [30:0]        tol_reg = 31'd16777;
    logic signed [31:0] src_reg = 32'sd4227;
    logic [15:0]        limit_reg = 16'd65535;

    // cells the stimulus has written so far
    bit written [0:4095];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic solve_grid();
        int     n;
        int     lim;
        int     count;
        int     p;
        bit     finished;
        longint acc;
        longint diff;
        longint big;
        logic signed [31:0] upd;
        n = (size_reg > 62) ? 62 : size_reg;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        count = 0;
        finished = 0;
        while (!finished)
        begin
            big = 0;
            count++;
            for (int i = 1; i <= n; i++)
                for (int j = 1; j <= n; j++)
                begin
                    p = i * gsp_pkg::GRID_STRIDE + j;
                    acc = longint'(grid_image[p - gsp_pkg::GRID_STRIDE])
                        + longint'(grid_image[p + gsp_pkg::GRID_STRIDE])
                        + longint'(grid_image[p - 1]) + longint'(grid_image[p + 1])
                        - longint'(src_reg);
                    upd = clamp32(acc >>> 2);
                    diff = longint'(upd) - longint'(grid_image[p]);
                    if (diff < 0)
                        diff = -diff;
                    if (diff > 64'hFFFFFFFF)
                        diff = 64'hFFFFFFFF;
                    grid_image[p] = upd;
                    if (diff > big)
                        big = diff;
                end
            if (big <= longint'(tol_reg))
            begin
                last_converged = 1'b1;
                finished = 1;
            end
            else if (count >= lim)
            begin
                last_converged = 1'b0;
                finished = 1;
            end
        end
        last_sweeps = count[15:0];
    endtask

    task automatic apply_cmd(cmd_word_t c);
        status_word_t s;
        s.read_value = '0;
        case (c.kind)
            gsp_pkg::KIND_WRITE: grid_image[{c.row, c.col}] = c.value;
            gsp_pkg::KIND_RUN:   solve_grid();
            gsp_pkg::KIND_READ:  s.read_value = grid_image[{c.row, c.col}];
            default: ;
        endcase
        s.sweep_count = last_sweeps;
        s.converged = last_converged;
        awaited_status.push_back(s);
    endtask

    // driver
    int gap = 0;
    bit burst = 0;
    always @(posedge clk or negedge rst_n)
    begin
        cmd_word_t c;
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= gsp_pkg::KIND_WRITE;
            row <= '0;
            col <= '0;
            cell_value <= '0;
            gap = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                apply_cmd('{kind, row, col, cell_value});
            if ($urandom_range(0, 49) == 0)
                burst = !burst;
            if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                kind <= c.kind;
                row <= c.row;
                col <= c.col;
                cell_value <= c.value;
                start <= 1'b1;
                if (!burst && $urandom_range(0, 9) >= 6)
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        status_word_t e;
        if (rst_n && done)
        begin
            if (awaited_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result word with nothing awaited: rv=%h sc=%0d cv=%b",
                             read_value, sweep_count, converged);
            end
            else
            begin
                e = awaited_status.pop_front();
                if (read_value !== e.read_value || sweep_count !== e.sweep_count
                    || converged !== e.converged)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp rv=%h sc=%0d cv=%b got rv=%h sc=%0d cv=%b",
                                 e.read_value, e.sweep_count, e.converged,
                                 read_value, sweep_count, converged);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || awaited_status.size() > 0 || start || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gsp_pkg::REG_GRID_N:      size_reg = data[5:0];
            gsp_pkg::REG_TOLERANCE:   tol_reg = data[30:0];
            gsp_pkg::REG_SOURCE_TERM: src_reg = data;
            gsp_pkg::REG_MAX_SWEEPS:  limit_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int n, logic [31:0] tol, logic [31:0] src, int lim);
        write_reg(gsp_pkg::REG_GRID_N, 32'(n));
        write_reg(gsp_pkg::REG_TOLERANCE, tol);
        write_reg(gsp_pkg::REG_SOURCE_TERM, src);
        write_reg(gsp_pkg::REG_MAX_SWEEPS, 32'(lim));
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000;
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] k, int r, int c, logic signed [31:0] v);
        pending_cmds.push_back('{k, r[5:0], c[5:0], v});
        if (k == gsp_pkg::KIND_WRITE)
            written[r * gsp_pkg::GRID_STRIDE + c] = 1;
    endtask

    // fill every cell a run of size n touches
    task automatic fill_grid(int n);
        int m;
        m = (n > 62) ? 62 : n;
        for (int r = 0; r <= m + 1; r++)
            for (int c = 0; c <= m + 1; c++)
                push_cmd(gsp_pkg::KIND_WRITE, r, c, pick_value());
    endtask

    initial
    begin
        int issued;
        int n;
        int r;
        int c;
        int sel;
        logic [31:0] tol;
        logic [31:0] src;
        int lim;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes at the far corners, unknown kind, a single-cell run
        set_all(1, 0, 32'h80000000, 1);
        push_cmd(gsp_pkg::KIND_WRITE, 0, 0, 32'sh7FFFFFFF);
        push_cmd(gsp_pkg::KIND_WRITE, 0, 1, 32'sh7FFFFFFF);
        push_cmd(gsp_pkg::KIND_WRITE, 2, 1, 32'sh7FFFFFFF);
        push_cmd(gsp_pkg::KIND_WRITE, 1, 0, 32'sh7FFFFFFF);
        push_cmd(gsp_pkg::KIND_WRITE, 1, 2, 32'sh7FFFFFFF);
        push_cmd(gsp_pkg::KIND_WRITE, 1, 1, 32'sh80000000);
        push_cmd(gsp_pkg::KIND_WRITE, 63, 63, 32'sh80000000);
        push_cmd(gsp_pkg::KIND_WRITE, 63, 0, 32'sh00000000);
        push_cmd(gsp_pkg::KIND_READ, 63, 63, 0);
        push_cmd(gsp_pkg::KIND_READ, 63, 0, 0);
        push_cmd(gsp_pkg::KIND_NOP, 63, 63, 32'shFFFFFFFF);
        push_cmd(gsp_pkg::KIND_RUN, 0, 0, 0);
        push_cmd(gsp_pkg::KIND_READ, 1, 1, 0);
        push_cmd(gsp_pkg::KIND_RUN, 0, 0, 0);
        push_cmd(gsp_pkg::KIND_READ, 1, 1, 0);
        push_cmd(gsp_pkg::KIND_NOP, 0, 0, 0);
        wait_idle();

        // empty grid: one sweep, converged
        set_all(0, 32'h7FFFFFFF, 0, 0);
        push_cmd(gsp_pkg::KIND_RUN, 0, 0, 0);
        wait_idle();

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 5);
            case ($urandom_range(0, 3))
                0:       tol = 0;
                1:       tol = 32'h7FFFFFFF;
                2:       tol = $urandom() & 32'h7FFFFFFF;
                default: tol = $urandom_range(0, 32'h00400000);
            endcase
            case ($urandom_range(0, 4))
                0:       src = 32'h80000000;
                1:       src = 32'h7FFFFFFF;
                2:       src = $urandom();
                default: src = $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
            endcase
            lim = (tol == 32'h7FFFFFFF) ? 65535 : $urandom_range(0, 12);
            set_all(n, tol, src, lim);
            fill_grid(n);
            issued += (n + 2) * (n + 2);
            repeat ($urandom_range(60, 150))
            begin
                sel = $urandom_range(0, 99);
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
                if (sel < 45)
                    push_cmd(gsp_pkg::KIND_WRITE, r, c, pick_value());
                else if (sel < 88)
                begin
                    if (!written[r * gsp_pkg::GRID_STRIDE + c] || sel < 70)
                    begin
                        r = $urandom_range(0, n + 1);
                        c = $urandom_range(0, n + 1);
                    end
                    push_cmd(gsp_pkg::KIND_READ, r, c, pick_value());
                end
                else if (sel < 95)
                    push_cmd(gsp_pkg::KIND_RUN, r, c, pick_value());
                else
                    push_cmd(gsp_pkg::KIND_NOP, r, c, pick_value());
                issued++;
            end
            wait_idle();
        end

        // full-size grid, then a size above the maximum with the widest limit
        set_all(62, 0, 32'h80000000, 1);
        fill_grid(62);
        push_cmd(gsp_pkg::KIND_RUN, 0, 0, 0);
        repeat (10)
            push_cmd(gsp_pkg::KIND_READ, $urandom_range(0, 63), $urandom_range(0, 63), 0);
        wait_idle();
        set_all(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 65535);
        push_cmd(gsp_pkg::KIND_RUN, 0, 0, 0);
        push_cmd(gsp_pkg::KIND_READ, 62, 62, 0);
        push_cmd(gsp_pkg::KIND_READ, 1, 1, 0);
        wait_idle();

        repeat (20) @(posedge clk);
        if (awaited_status.size() > 0)
            errors++;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
